### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define TCVF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define TCVF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tcvf_pkg.sv
// Shared types and constants of the traffic class vote filter.
package tcvf_pkg;

    // Class encoding, same as the port hint.
    typedef enum logic [2:0] {
        CLS_UNKNOWN   = 3'd0,
        CLS_VOIP      = 3'd1,
        CLS_GAMING    = 3'd2,
        CLS_VIDEO     = 3'd3,
        CLS_STREAMING = 3'd4,
        CLS_BULK      = 3'd5,
        CLS_TORRENT   = 3'd6
    } t_class;

    localparam int CLASS_COUNT = 7;

    // Depth of the vote window.
    localparam int VOTE_WINDOW = 3;

    // Candidate queue between classifier and voter.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Decision tree thresholds. Bandwidth is 33 bits wide.
    localparam logic [15:0] TORRENT_FLOWS   = 16'd100;
    localparam logic [32:0] BW_HEAVY        = 33'd500000;
    localparam logic [31:0] RX_CLOUD_GAME   = 32'd30000000;
    localparam logic [32:0] BW_GAMING_MAX   = 33'd20000000;
    localparam logic [32:0] BW_VOIP_MAX     = 33'd5000000;
    localparam logic [31:0] RX_DOWNLOAD     = 32'd5000000;
    localparam logic [19:0] SIZE_VOIP_MAX   = 20'd1920;
    localparam logic [32:0] BW_VOIP_LOW     = 33'd200000;
    localparam logic [19:0] SIZE_GAMING_MAX = 20'd5600;
    localparam logic [15:0] GAMING_FLOWS    = 16'd8;
    localparam logic [32:0] BW_GAMING_MIN   = 33'd100000;
    localparam logic [32:0] BW_VIDEO_MIN    = 33'd200000;
    localparam logic [32:0] BW_VIDEO_MAX    = 33'd8000000;
    localparam logic [32:0] BW_HINT_MIN     = 33'd50000;

    // One candidate as it travels from classifier to queue to voter.
    typedef struct packed {
        logic   valid;
        t_class cls;
    } t_cand_item;

endpackage

### design/tcvf_if.sv
// Channel interfaces for samples in and classification results out.
interface tcvf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] tx_rate;
    logic [31:0] rx_rate;
    logic [15:0] flow_count;
    logic [15:0] udp_count;
    logic        dominant_flow;
    logic [19:0] mean_packet_size;
    logic [2:0]  port_hint;

    modport source (
        output valid, tx_rate, rx_rate, flow_count, udp_count, dominant_flow,
               mean_packet_size, port_hint,
        input  ready
    );
    modport sink (
        input  valid, tx_rate, rx_rate, flow_count, udp_count, dominant_flow,
               mean_packet_size, port_hint,
        output ready
    );
endinterface

interface tcvf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] current_class;
    logic [2:0] sample_class;
    logic       class_changed;

    modport source (
        output valid, current_class, sample_class, class_changed,
        input  ready
    );
    modport sink (
        input  valid, current_class, sample_class, class_changed,
        output ready
    );
endinterface

### design/traffic_class_vote_filter_unit.sv
// Top level of the traffic class vote filter.
// Each sample of device traffic metrics gets a candidate class from a first-match
// decision tree; the candidate is voted over the last VOTE_WINDOW samples and one
// result (settled class, candidate, change flag) comes out per sample, in order.
// The block takes one sample per clock cycle unless output back-pressure fills the
// queue. A sample's result passes through the classifier register, the two-entry
// candidate queue and the result register, in that order. The queue lets the
// input side keep accepting while a result waits to be taken.
module traffic_class_vote_filter_unit #(
    parameter int VOTE_WINDOW = tcvf_pkg::VOTE_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcvf_in_if.sink     i_in,
    tcvf_out_if.source  o_out
);

    tcvf_pkg::t_cand_item cand;
    tcvf_pkg::t_cand_item head;
    logic                 cand_ready;
    logic                 pop;

    // Classifier.
    tcvf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_cand       (cand),
        .i_cand_ready (cand_ready)
    );

    // Candidate queue.
    tcvf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cand),
        .o_push_ready (cand_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Voter and result register.
    tcvf_back #(
        .VOTE_WINDOW (VOTE_WINDOW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### design/tcvf_front.sv
// Front end: accepts samples and registers the decision tree candidate.
module tcvf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tcvf_in_if.sink              i_in,
    output tcvf_pkg::t_cand_item o_cand,
    input  logic                 i_cand_ready
);

    logic [32:0]       bw;
    logic [35:0]       tx_x10;
    logic [32:0]       rx_p1;
    logic [33:0]       rx_x3;
    logic [17:0]       udp_x4;
    logic              ratio_low;
    logic              udp_high;
    logic              size_nz;
    logic              flows_nz;
    logic              hint_gaming;
    logic              hint_voip;
    logic              hint_video;
    logic              hint_streaming;
    tcvf_pkg::t_class  hint;
    tcvf_pkg::t_class  n_cls;
    logic              accept;

    logic              r_valid;
    tcvf_pkg::t_class  r_cls;

    // Exact ratio tests by cross-multiplication with shift-and-add.
    always_comb begin
        bw        = {1'b0, i_in.tx_rate} + {1'b0, i_in.rx_rate};
        tx_x10    = {1'b0, i_in.tx_rate, 3'b000} + {3'b000, i_in.tx_rate, 1'b0};
        rx_p1     = {1'b0, i_in.rx_rate} + 33'd1;
        rx_x3     = {rx_p1, 1'b0} + {1'b0, rx_p1};
        ratio_low = tx_x10 < {2'b00, rx_x3};
        udp_x4    = {i_in.udp_count, 2'b00};
        flows_nz  = i_in.flow_count != 16'd0;
        udp_high  = flows_nz && (udp_x4 >= {2'b00, i_in.flow_count});
        size_nz   = i_in.mean_packet_size != 20'd0;
    end

    // A hint outside the encoding counts as unknown.
    always_comb begin
        if (i_in.port_hint == 3'd7) begin
            hint = tcvf_pkg::CLS_UNKNOWN;
        end else begin
            hint = tcvf_pkg::t_class'(i_in.port_hint);
        end
        hint_gaming    = hint == tcvf_pkg::CLS_GAMING;
        hint_voip      = hint == tcvf_pkg::CLS_VOIP;
        hint_video     = hint == tcvf_pkg::CLS_VIDEO;
        hint_streaming = hint == tcvf_pkg::CLS_STREAMING;
    end

    // First-match decision tree.
    always_comb begin
        if (i_in.flow_count > tcvf_pkg::TORRENT_FLOWS && bw > tcvf_pkg::BW_HEAVY) begin
            n_cls = tcvf_pkg::CLS_TORRENT;
        end else if (udp_high && i_in.rx_rate > tcvf_pkg::RX_CLOUD_GAME && ratio_low) begin
            n_cls = hint_gaming ? tcvf_pkg::CLS_GAMING : tcvf_pkg::CLS_STREAMING;
        end else if (udp_high && bw > tcvf_pkg::BW_HEAVY) begin
            n_cls = hint_video ? tcvf_pkg::CLS_VIDEO : tcvf_pkg::CLS_GAMING;
        end else if (i_in.dominant_flow) begin
            if (hint_gaming && bw <= tcvf_pkg::BW_GAMING_MAX) begin
                n_cls = tcvf_pkg::CLS_GAMING;
            end else if (hint_voip && bw <= tcvf_pkg::BW_VOIP_MAX) begin
                n_cls = tcvf_pkg::CLS_VOIP;
            end else if (hint_video) begin
                n_cls = tcvf_pkg::CLS_VIDEO;
            end else if (hint_streaming) begin
                n_cls = tcvf_pkg::CLS_STREAMING;
            end else begin
                n_cls = tcvf_pkg::CLS_BULK;
            end
        end else if (i_in.rx_rate > tcvf_pkg::RX_DOWNLOAD && ratio_low && !udp_high) begin
            if (hint_gaming && bw <= tcvf_pkg::BW_GAMING_MAX) begin
                n_cls = tcvf_pkg::CLS_GAMING;
            end else if (hint_streaming) begin
                n_cls = tcvf_pkg::CLS_STREAMING;
            end else begin
                n_cls = tcvf_pkg::CLS_BULK;
            end
        end else if (size_nz && i_in.mean_packet_size < tcvf_pkg::SIZE_VOIP_MAX
                     && bw < tcvf_pkg::BW_VOIP_LOW) begin
            n_cls = tcvf_pkg::CLS_VOIP;
        end else if (size_nz && i_in.mean_packet_size < tcvf_pkg::SIZE_GAMING_MAX
                     && flows_nz && i_in.flow_count < tcvf_pkg::GAMING_FLOWS
                     && bw > tcvf_pkg::BW_GAMING_MIN) begin
            n_cls = tcvf_pkg::CLS_GAMING;
        end else if (bw >= tcvf_pkg::BW_VIDEO_MIN && bw <= tcvf_pkg::BW_VIDEO_MAX) begin
            n_cls = tcvf_pkg::CLS_VIDEO;
        end else if (hint != tcvf_pkg::CLS_UNKNOWN && bw > tcvf_pkg::BW_HINT_MIN) begin
            n_cls = hint;
        end else begin
            n_cls = tcvf_pkg::CLS_UNKNOWN;
        end
    end

    // The candidate register drains into the queue whenever it has room.
    assign i_in.ready = !r_valid || i_cand_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_cand.valid = r_valid;
    assign o_cand.cls   = r_cls;

endmodule

### design/tcvf_queue.sv
// Short candidate queue that decouples the classifier from the voter.
module tcvf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcvf_pkg::t_cand_item i_push,
    output logic                 o_push_ready,
    output tcvf_pkg::t_cand_item o_head,
    input  logic                 i_pop
);

    tcvf_pkg::t_class                     r_mem [tcvf_pkg::QUEUE_DEPTH];
    logic [tcvf_pkg::QUEUE_PTR_W-1:0]     r_wptr;
    logic [tcvf_pkg::QUEUE_PTR_W-1:0]     r_rptr;
    logic [tcvf_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [tcvf_pkg::QUEUE_CNT_W-1:0]     n_count;
    logic                                 push;
    logic                                 pop;

    assign o_push_ready = r_count != tcvf_pkg::QUEUE_CNT_W'(tcvf_pkg::QUEUE_DEPTH);
    assign push         = i_push.valid && o_push_ready;
    assign pop          = i_pop && (r_count != '0);

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointer wrap at the queue depth.
    function automatic logic [tcvf_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [tcvf_pkg::QUEUE_PTR_W-1:0] p
    );
        if (p == tcvf_pkg::QUEUE_PTR_W'(tcvf_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_push.cls;
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.cls   = r_mem[r_rptr];

endmodule

### design/tcvf_back.sv
// Back end: vote window, settled class and the result register.
module tcvf_back #(
    parameter int VOTE_WINDOW = tcvf_pkg::VOTE_WINDOW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcvf_pkg::t_cand_item i_head,
    output logic                 o_pop,
    tcvf_out_if.source           o_out
);

    localparam int CNT_W = $clog2(VOTE_WINDOW + 1);

    tcvf_pkg::t_class  r_hist [VOTE_WINDOW];
    logic [VOTE_WINDOW-1:0] r_hist_vld;
    tcvf_pkg::t_class  r_settled;
    logic              r_out_valid;
    tcvf_pkg::t_class  r_out_current;
    tcvf_pkg::t_class  r_out_sample;
    logic              r_out_changed;

    tcvf_pkg::t_class  n_hist [VOTE_WINDOW];
    logic [VOTE_WINDOW-1:0] n_hist_vld;
    tcvf_pkg::t_class  n_settled;
    logic [CNT_W-1:0]  cnt [tcvf_pkg::CLASS_COUNT];
    logic              all_unknown;

    // Take the next candidate when the result register is free.
    assign o_pop = i_head.valid && (!r_out_valid || o_out.ready);

    // Window shifts by one; newest entry enters at the top.
    always_comb begin
        for (int i = 0; i < VOTE_WINDOW - 1; i++) begin
            n_hist[i]     = r_hist[i+1];
            n_hist_vld[i] = r_hist_vld[i+1];
        end
        n_hist[VOTE_WINDOW-1]     = i_head.cls;
        n_hist_vld[VOTE_WINDOW-1] = 1'b1;
    end

    // Votes per class over the filled entries.
    always_comb begin
        for (int c = 0; c < tcvf_pkg::CLASS_COUNT; c++) begin
            cnt[c] = '0;
            for (int i = 0; i < VOTE_WINDOW; i++) begin
                if (n_hist_vld[i] && n_hist[i] == tcvf_pkg::t_class'(c)) begin
                    cnt[c] = cnt[c] + 1'b1;
                end
            end
        end
        all_unknown = (&n_hist_vld)
                      && (cnt[tcvf_pkg::CLS_UNKNOWN] == CNT_W'(VOTE_WINDOW));
    end

    // Lowest known class with two votes wins; a window of unknowns resets.
    always_comb begin
        n_settled = r_settled;
        for (int c = tcvf_pkg::CLASS_COUNT - 1; c >= 1; c--) begin
            if (cnt[c] >= CNT_W'(2)) begin
                n_settled = tcvf_pkg::t_class'(c);
            end
        end
        if (all_unknown) begin
            n_settled = tcvf_pkg::CLS_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld  <= '0;
            r_settled   <= tcvf_pkg::CLS_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hist_vld  <= n_hist_vld;
                r_settled   <= n_settled;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_hist        <= n_hist;
            r_out_current <= n_settled;
            r_out_sample  <= i_head.cls;
            r_out_changed <= n_settled != r_settled;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_class = r_out_current;
    assign o_out.sample_class  = r_out_sample;
    assign o_out.class_changed = r_out_changed;

endmodule

### design/tcvf_checker.sv
// Port-level checker of the traffic class vote filter and its bind.
`include "assert_macros.svh"

module tcvf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_current_class,
    input logic [2:0] i_sample_class,
    input logic       i_class_changed
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_in_flight;
    logic [2:0] r_last_class;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track items in flight and the last delivered settled class.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight  <= '0;
            r_last_class <= 3'(tcvf_pkg::CLS_UNKNOWN);
        end else begin
            r_in_flight <= r_in_flight + 3'(in_acc) - 3'(out_acc);
            if (out_acc) begin
                r_last_class <= i_current_class;
            end
        end
    end

    `TCVF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_current_class) && $stable(i_sample_class) && $stable(i_class_changed), "result changed while stalled")
    `TCVF_ASSERT(a_change_flag, i_clk, i_rst_n, out_acc |-> (i_class_changed == (i_current_class != r_last_class)), "change flag disagrees with previous class")
    `TCVF_ASSERT(a_fallback, i_clk, i_rst_n, out_acc && i_class_changed && i_current_class == 3'(tcvf_pkg::CLS_UNKNOWN) |-> i_sample_class == 3'(tcvf_pkg::CLS_UNKNOWN), "fallback to unknown on a known sample")
    `TCVF_ASSERT_ALWAYS(a_no_phantom, i_clk, i_rst_n && i_out_valid |-> r_in_flight != 3'd0, "result without an accepted item")

endmodule

bind traffic_class_vote_filter_unit tcvf_checker u_tcvf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_current_class (o_out.current_class),
    .i_sample_class  (o_out.sample_class),
    .i_class_changed (o_out.class_changed)
);
